// ----- hw/rtl/nehl_pkg.sv -----
// ----------------------------------------------------------------------------
// nehl_pkg
// Shared types and constants for the nearest expert hyperplane labeller.
// ----------------------------------------------------------------------------
`default_nettype none

package nehl_pkg;

  localparam int DIST_W = 37;
  localparam int DOT_W  = 38;
  localparam int BIAS_W = 36;
  localparam int SEP_W  = 39;
  localparam int TAG_W  = 16;
  localparam int IDX_W  = 4;
  localparam int FV_W   = 16;
  localparam int CFG_W  = 5;

  localparam logic [1:0] REQ_MID  = 2'd0;
  localparam logic [1:0] REQ_DIF  = 2'd1;
  localparam logic [1:0] REQ_BIAS = 2'd2;
  localparam logic [1:0] REQ_FEAT = 2'd3;

  localparam logic [1:0] LBL_NEG  = 2'b11;
  localparam logic [1:0] LBL_ZERO = 2'b00;
  localparam logic [1:0] LBL_POS  = 2'b01;

  localparam logic [CFG_W-1:0] ACTIVE_RST = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEAT,
    ST_SRCH,
    ST_WAIT
  } state_t;

  // token travelling along the cell chain
  typedef struct packed {
    logic             feat;
    logic             srch;
    logic [IDX_W-1:0] fi;
  } tok_ctl_t;

  // table write strobes broadcast to all cells
  typedef struct packed {
    logic             mid_we;
    logic             dif_we;
    logic             bias_we;
    logic [IDX_W-1:0] ex;
    logic [IDX_W-1:0] fi;
  } ld_ctl_t;

  // running nearest-expert record handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [DIST_W-1:0] near_dist;
    logic [DOT_W-1:0]  dot;
    logic [BIAS_W-1:0] bias;
    logic [IDX_W-1:0]  idx;
  } best_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nehl_if.sv -----
// ----------------------------------------------------------------------------
// nehl_in_if / nehl_out_if
// Valid/ready channels for request items and label results.
// ----------------------------------------------------------------------------
`default_nettype none

interface nehl_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      req_type;
  logic [nehl_pkg::IDX_W-1:0]      expert_index;
  logic [nehl_pkg::IDX_W-1:0]      feature_index;
  logic signed [nehl_pkg::FV_W-1:0]   feature_value;
  logic signed [nehl_pkg::BIAS_W-1:0] bias_value;
  logic [nehl_pkg::TAG_W-1:0]      vertex_tag;
  logic                            last_feature;

  modport source (output valid, req_type, expert_index, feature_index, feature_value,
                  bias_value, vertex_tag, last_feature, input ready);
  modport sink (input valid, req_type, expert_index, feature_index, feature_value,
                bias_value, vertex_tag, last_feature, output ready);
endinterface

interface nehl_out_if;
  logic                       valid;
  logic                       ready;
  logic [nehl_pkg::TAG_W-1:0] out_vertex_tag;
  logic signed [1:0]          cluster_label;
  logic [nehl_pkg::IDX_W-1:0] chosen_expert;

  modport source (output valid, out_vertex_tag, cluster_label, chosen_expert, input ready);
  modport sink (input valid, out_vertex_tag, cluster_label, chosen_expert, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/nearest_expert_hyperplane_label_top.sv -----
// ----------------------------------------------------------------------------
// nearest_expert_hyperplane_label_top
// Chain of expert cells; a feature walks the chain, a final search pass
// picks the nearest expert and signs its separation value.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | req_type, indexes, value, bias, tag, last
//  out_ch  | out | valid/ready   | out_vertex_tag, cluster_label, chosen_expert
//  cfg_    | in  | cfg_we        | cfg_wdata = active_experts
//
//  A load transfer writes the tables and leaves the block ready for the next
//  item. A feature transfer sends a token walking one cell per cycle through
//  the cell read/multiply/add stages. The last feature adds a search pass and
//  parks the result when the output register is free. Reset clears control
//  and accumulators; tables are not cleared. in_ch.ready is low while an item
//  is in the chain or a result waits to move into the output register.
`default_nettype none

module nearest_expert_hyperplane_label_top #(
  parameter int MAX_EXPERTS  = 16,
  parameter int MAX_FEATURES = 16,
  parameter int VALUE_WIDTH  = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  nehl_in_if.sink                          in_ch,
  nehl_out_if.source                       out_ch,
  input  wire logic                        cfg_we,
  input  wire logic [nehl_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int NW   = $clog2(MAX_EXPERTS + 1);
  localparam int CW   = $clog2(MAX_EXPERTS + 4);
  localparam int DONE = MAX_EXPERTS + 2;

  nehl_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [nehl_pkg::CFG_W-1:0] active_r;
  logic [NW-1:0]    n_eff;
  logic             acc;
  logic             fi_ok;
  logic             last_r;
  logic [nehl_pkg::TAG_W-1:0] tag_r;
  logic signed [VALUE_WIDTH-1:0] xin;
  logic signed [VALUE_WIDTH-1:0] head_x_r;
  nehl_pkg::tok_ctl_t head_ctl_r, head_ctl_nxt;
  nehl_pkg::ld_ctl_t  ld;

  nehl_pkg::tok_ctl_t            ctl_c  [MAX_EXPERTS+1];
  logic signed [VALUE_WIDTH-1:0] x_c    [MAX_EXPERTS+1];
  nehl_pkg::best_t               best_c [MAX_EXPERTS+1];

  logic                          chain_done;
  nehl_pkg::best_t               fin;
  logic signed [nehl_pkg::SEP_W-1:0] sep;
  logic [1:0]                    lbl;
  logic [1:0]                    pend_lbl_r;
  logic [nehl_pkg::IDX_W-1:0]    pend_idx_r;
  logic                          out_valid_r;
  logic [nehl_pkg::TAG_W-1:0]    out_tag_r;
  logic [1:0]                    out_lbl_r;
  logic [nehl_pkg::IDX_W-1:0]    out_idx_r;
  logic                          out_free;
  logic                          out_load;

  assign acc   = in_ch.valid && in_ch.ready;
  assign fi_ok = (32'(in_ch.feature_index) < MAX_FEATURES);
  assign xin   = VALUE_WIDTH'(in_ch.feature_value);

  always_comb begin
    if (active_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(active_r) > MAX_EXPERTS) begin
      n_eff = NW'(MAX_EXPERTS);
    end else begin
      n_eff = NW'(active_r);
    end
  end

  always_comb begin
    ld.mid_we  = acc && (in_ch.req_type == nehl_pkg::REQ_MID) && fi_ok;
    ld.dif_we  = acc && (in_ch.req_type == nehl_pkg::REQ_DIF) && fi_ok;
    ld.bias_we = acc && (in_ch.req_type == nehl_pkg::REQ_BIAS);
    ld.ex      = in_ch.expert_index;
    ld.fi      = in_ch.feature_index;
  end

  assign ctl_c[0]  = head_ctl_r;
  assign x_c[0]    = head_x_r;
  assign best_c[0] = '0;

  for (genvar g = 0; g < MAX_EXPERTS; g++) begin : g_cell
    nehl_cell #(
      .E           (g),
      .MAX_EXPERTS (MAX_EXPERTS),
      .MAX_FEATURES(MAX_FEATURES),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .n_eff  (n_eff),
      .ld     (ld),
      .ld_val (xin),
      .ld_bias(in_ch.bias_value),
      .ctl_i  (ctl_c[g]),
      .x_i    (x_c[g]),
      .best_i (best_c[g]),
      .ctl_o  (ctl_c[g+1]),
      .x_o    (x_c[g+1]),
      .best_o (best_c[g+1])
    );
  end

  assign chain_done = ctl_c[MAX_EXPERTS].srch;
  assign fin        = best_c[MAX_EXPERTS];
  assign sep = $signed({fin.dot[nehl_pkg::DOT_W-1], fin.dot})
             - $signed({{3{fin.bias[nehl_pkg::BIAS_W-1]}}, fin.bias});

  always_comb begin
    if (sep == '0) begin
      lbl = nehl_pkg::LBL_ZERO;
    end else if (sep[nehl_pkg::SEP_W-1]) begin
      lbl = nehl_pkg::LBL_NEG;
    end else begin
      lbl = nehl_pkg::LBL_POS;
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    head_ctl_nxt = '0;
    out_load     = 1'b0;
    in_ch.ready  = 1'b0;
    unique case (state_r)
      nehl_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        // ready is high here, so valid alone marks the transfer
        if (in_ch.valid && (in_ch.req_type == nehl_pkg::REQ_FEAT)) begin
          head_ctl_nxt.feat = fi_ok;
          head_ctl_nxt.fi   = in_ch.feature_index;
          cnt_nxt           = '0;
          state_nxt         = nehl_pkg::ST_FEAT;
        end
      end
      nehl_pkg::ST_FEAT: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(DONE)) begin
          if (last_r) begin
            head_ctl_nxt.srch = 1'b1;
            state_nxt         = nehl_pkg::ST_SRCH;
          end else begin
            state_nxt = nehl_pkg::ST_IDLE;
          end
        end
      end
      nehl_pkg::ST_SRCH: begin
        if (chain_done) state_nxt = nehl_pkg::ST_WAIT;
      end
      nehl_pkg::ST_WAIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = nehl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nehl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nehl_pkg::ST_IDLE;
      cnt_r       <= '0;
      head_ctl_r  <= '0;
      active_r    <= nehl_pkg::ACTIVE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      head_ctl_r <= head_ctl_nxt;
      if (cfg_we) active_r <= cfg_wdata;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      head_x_r <= xin;
      tag_r    <= in_ch.vertex_tag;
      last_r   <= in_ch.last_feature;
    end
    if (chain_done) begin
      pend_lbl_r <= lbl;
      pend_idx_r <= fin.idx;
    end
    if (out_load) begin
      out_tag_r <= tag_r;
      out_lbl_r <= pend_lbl_r;
      out_idx_r <= pend_idx_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_vertex_tag = out_tag_r;
  assign out_ch.cluster_label  = out_lbl_r;
  assign out_ch.chosen_expert  = out_idx_r;

  a_done_in_srch: assert property (@(posedge clk) disable iff (!rst_n)
    chain_done |-> state_r == nehl_pkg::ST_SRCH)
    else $error("search token left chain outside search phase");

  a_feat_start: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.req_type == nehl_pkg::REQ_FEAT) |=> state_r == nehl_pkg::ST_FEAT)
    else $error("feature transfer did not start chain walk");

  a_lbl_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.cluster_label == nehl_pkg::LBL_NEG ||
                      out_ch.cluster_label == nehl_pkg::LBL_ZERO ||
                      out_ch.cluster_label == nehl_pkg::LBL_POS))
    else $error("illegal label code");

  a_load_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.req_type != nehl_pkg::REQ_FEAT) |=> state_r == nehl_pkg::ST_IDLE)
    else $error("load transfer left idle");

endmodule

`default_nettype wire

// ----- hw/rtl/nehl_cell.sv -----
// ----------------------------------------------------------------------------
// nehl_cell
// One expert: its vector rows, bias, accumulators and a chain stage.
// ----------------------------------------------------------------------------
`default_nettype none

module nehl_cell #(
  parameter int E            = 0,
  parameter int MAX_EXPERTS  = 16,
  parameter int MAX_FEATURES = 16,
  parameter int VALUE_WIDTH  = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [$clog2(MAX_EXPERTS+1)-1:0]    n_eff,
  input  wire nehl_pkg::ld_ctl_t                   ld,
  input  wire logic signed [VALUE_WIDTH-1:0]       ld_val,
  input  wire logic [nehl_pkg::BIAS_W-1:0]         ld_bias,
  input  wire nehl_pkg::tok_ctl_t                  ctl_i,
  input  wire logic signed [VALUE_WIDTH-1:0]       x_i,
  input  wire nehl_pkg::best_t                     best_i,
  output nehl_pkg::tok_ctl_t                       ctl_o,
  output logic signed [VALUE_WIDTH-1:0]            x_o,
  output nehl_pkg::best_t                          best_o
);

  localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int PW = 2 * (VALUE_WIDTH + 1);
  localparam int DW = 2 * VALUE_WIDTH;

  logic signed [VALUE_WIDTH-1:0] mid_mem [MAX_FEATURES];
  logic signed [VALUE_WIDTH-1:0] dif_mem [MAX_FEATURES];
  logic [nehl_pkg::BIAS_W-1:0]   bias_r;

  logic                          hit;
  logic                          active;
  logic [FW-1:0]                 wr_idx;
  logic [FW-1:0]                 rd_idx;

  logic                          rd_v_r;
  logic signed [VALUE_WIDTH-1:0] mid_rd_r, dif_rd_r, xs_r;
  logic                          pr_v_r;
  logic signed [PW-1:0]          sq_r;
  logic signed [DW-1:0]          dp_r;
  logic signed [VALUE_WIDTH:0]   df;

  logic [nehl_pkg::DIST_W-1:0]   dist_acc_r;
  logic [nehl_pkg::DOT_W-1:0]    dot_acc_r;

  nehl_pkg::tok_ctl_t            ctl_r;
  logic signed [VALUE_WIDTH-1:0] x_r;
  nehl_pkg::best_t               best_r, best_nxt;

  assign hit    = (E < 16) && (ld.ex == nehl_pkg::IDX_W'(E));
  assign active = (32'(n_eff) > E);
  assign wr_idx = FW'(ld.fi);
  assign rd_idx = FW'(ctl_i.fi);

  always_ff @(posedge clk) begin
    if (hit && ld.mid_we) mid_mem[wr_idx] <= ld_val;
    if (hit && ld.dif_we) dif_mem[wr_idx] <= ld_val;
    if (hit && ld.bias_we) bias_r <= ld_bias;
    mid_rd_r <= mid_mem[rd_idx];
    dif_rd_r <= dif_mem[rd_idx];
    xs_r     <= x_i;
  end

  assign df = (VALUE_WIDTH+1)'(xs_r) - (VALUE_WIDTH+1)'(mid_rd_r);

  always_ff @(posedge clk) begin
    sq_r <= df * df;
    dp_r <= xs_r * dif_rd_r;
  end

  // nearest search: strict compare keeps the lower index on ties
  always_comb begin
    best_nxt = best_i;
    if (active && (!best_i.found || (dist_acc_r < best_i.near_dist))) begin
      best_nxt.found     = 1'b1;
      best_nxt.near_dist = dist_acc_r;
      best_nxt.dot       = dot_acc_r;
      best_nxt.bias      = bias_r;
      best_nxt.idx       = nehl_pkg::IDX_W'(E);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r     <= 1'b0;
      pr_v_r     <= 1'b0;
      dist_acc_r <= '0;
      dot_acc_r  <= '0;
      ctl_r      <= '0;
    end else begin
      rd_v_r <= ctl_i.feat && active;
      pr_v_r <= rd_v_r;
      ctl_r  <= ctl_i;
      if (ctl_i.srch) begin
        dist_acc_r <= '0;
        dot_acc_r  <= '0;
      end else if (pr_v_r) begin
        dist_acc_r <= dist_acc_r + nehl_pkg::DIST_W'($unsigned(sq_r));
        dot_acc_r  <= dot_acc_r + nehl_pkg::DOT_W'(dp_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_i;
    best_r <= best_nxt;
  end

  assign ctl_o  = ctl_r;
  assign x_o    = x_r;
  assign best_o = best_r;

endmodule

`default_nettype wire
